// File: src/atrp_pkg.sv
// Shared types and constants of the AT response line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package atrp_pkg;

	// Parse states; code 7 is unused and behaves as ST_CRLF.
	typedef enum logic [2:0] {
		ST_CRLF    = 3'd0,
		ST_NEWLINE = 3'd1,
		ST_DATA    = 3'd2,
		ST_IGNORE  = 3'd3,
		ST_KWAIT   = 3'd4,
		ST_COLON   = 3'd5,
		ST_SPACE   = 3'd6
	} atrp_state_t;

	// Input kinds and result kinds.
	localparam logic IN_BYTE     = 1'b0;
	localparam logic IN_NEW_RESP = 1'b1;
	localparam logic OUT_CHAR    = 1'b0;
	localparam logic OUT_LINE_END = 1'b1;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Queue between the parser and the output stage.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       kind;
		logic [7:0] chr;
	} atrp_result_t;

	// One parsed byte: one or two results.
	typedef struct packed {
		logic         two;
		atrp_result_t r0;
		atrp_result_t r1;
	} atrp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} atrp_qstat_t;

endpackage

`default_nettype wire

// File: src/atrp_front.sv
// Front part: accepts input bytes, keeps the parse state and the mode register,
// and turns each byte that has results into a queue entry. Depends on atrp_pkg.
`default_nettype none

module atrp_front import atrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_kind,
	input  wire logic [7:0]  in_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire atrp_qstat_t qstat,
	output logic             push,
	output atrp_entry_t      push_entry
);

	atrp_state_t state_q, state_d;
	logic        lht_q, lht_d;
	logic        plus_mode_q;
	logic        accept;
	logic        is_eol;
	logic        has_out;

	assign in_ready  = !qstat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign is_eol    = (in_byte == CH_CR) || (in_byte == CH_LF);

	// Next state and line-text flag.
	always_comb begin
		state_d = state_q;
		lht_d   = lht_q;
		if (in_kind == IN_NEW_RESP) begin
			state_d = ST_CRLF;
			lht_d   = 1'b0;
		end else begin
			case (state_q)
				ST_DATA: begin
					state_d = is_eol ? ST_CRLF : ST_DATA;
					lht_d   = !is_eol;
				end
				ST_IGNORE: begin
					state_d = ST_IGNORE;
				end
				ST_KWAIT: begin
					if (in_byte == CH_K) begin
						state_d = ST_IGNORE;
					end else begin
						state_d = is_eol ? ST_CRLF : ST_DATA;
						lht_d   = !is_eol;
					end
				end
				ST_COLON: begin
					if (in_byte == CH_COLON) begin
						state_d = ST_SPACE;
					end
				end
				ST_SPACE: begin
					if (in_byte != CH_SPACE) begin
						state_d = is_eol ? ST_CRLF : ST_DATA;
						lht_d   = !is_eol;
					end
				end
				default: begin
					// Line separator, new line and the unused code.
					if (state_q != ST_NEWLINE && is_eol) begin
						state_d = ST_CRLF;
					end else if (in_byte == CH_PLUS) begin
						state_d = plus_mode_q ? ST_COLON : ST_IGNORE;
					end else if (in_byte == CH_O) begin
						state_d = ST_KWAIT;
					end else begin
						state_d = is_eol ? ST_CRLF : ST_DATA;
						lht_d   = !is_eol;
					end
				end
			endcase
		end
	end

	// Results of the byte.
	always_comb begin
		has_out            = 1'b0;
		push_entry.two     = 1'b0;
		push_entry.r0.kind = OUT_CHAR;
		push_entry.r0.chr  = in_byte;
		push_entry.r1.kind = OUT_CHAR;
		push_entry.r1.chr  = in_byte;
		if (in_kind == IN_BYTE) begin
			case (state_q)
				ST_DATA, ST_SPACE: begin
					if (state_q == ST_DATA || in_byte != CH_SPACE) begin
						if (is_eol) begin
							has_out            = plus_mode_q && lht_q;
							push_entry.r0.kind = OUT_LINE_END;
							push_entry.r0.chr  = 8'h00;
						end else begin
							has_out = 1'b1;
						end
					end
				end
				ST_IGNORE, ST_COLON: begin
					has_out = 1'b0;
				end
				ST_KWAIT: begin
					if (in_byte != CH_K) begin
						// The held O goes out, then the byte is parsed as data
						// with the line already carrying text.
						push_entry.r0.chr = CH_O;
						has_out           = 1'b1;
						if (is_eol) begin
							push_entry.two     = plus_mode_q;
							push_entry.r1.kind = OUT_LINE_END;
							push_entry.r1.chr  = 8'h00;
						end else begin
							push_entry.two = 1'b1;
						end
					end
				end
				default: begin
					if (!(state_q != ST_NEWLINE && is_eol) && in_byte != CH_PLUS
					    && in_byte != CH_O) begin
						if (is_eol) begin
							has_out            = plus_mode_q && lht_q;
							push_entry.r0.kind = OUT_LINE_END;
							push_entry.r0.chr  = 8'h00;
						end else begin
							has_out = 1'b1;
						end
					end
				end
			endcase
		end
	end

	assign push = accept && has_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CRLF;
			lht_q       <= 1'b0;
			plus_mode_q <= 1'b1;
		end else begin
			if (accept) begin
				state_q <= state_d;
				lht_q   <= lht_d;
			end
			if (cfg_valid && cfg_ready) begin
				plus_mode_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/atrp_queue.sv
// Short queue of parsed entries between the front and back parts.
// Depends on atrp_pkg.
`default_nettype none

module atrp_queue import atrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire atrp_entry_t push_entry,
	input  wire logic        pop,
	output atrp_entry_t      head,
	output atrp_qstat_t      qstat
);

	atrp_entry_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QDEPTH);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QDEPTH);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/atrp_back.sv
// Back part: drains queue entries into the output register, one result per cycle
// while out_ready lets the output register move on. Depends on atrp_pkg.
`default_nettype none

module atrp_back import atrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire atrp_entry_t head,
	input  wire atrp_qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [7:0]       out_char,
	output logic             out_last
);

	logic         valid_q;
	logic         sub_q;
	logic         load;
	logic         last_sel;
	atrp_result_t res_sel;
	atrp_result_t res_q;
	logic         last_q;

	assign load     = !qstat.empty && (!valid_q || out_ready);
	assign res_sel  = sub_q ? head.r1 : head.r0;
	assign last_sel = sub_q || !head.two;
	assign pop      = load && last_sel;

	assign out_valid = valid_q;
	assign out_kind  = res_q.kind;
	assign out_char  = res_q.chr;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= res_sel;
			last_q <= last_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= !last_sel;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/at_response_line_parser_core.sv
// Top level of the AT response line parser: front parser, entry queue, output stage.
// Depends on atrp_pkg, atrp_front, atrp_queue and atrp_back.
//
// Channel  | Direction | Handshake                    | Content
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser kind, tdata byte, tlast chunk end
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tuser result kind, tdata char, tlast
// cfg      | in        | cfg_valid/cfg_ready          | cfg_data plus_mode
//
// One input byte is accepted every cycle while the four-entry queue has room.
// An accepted byte's entry is written into a queue slot and then loaded into the
// output register, which sends one result per cycle while m_axis_tready is high;
// a byte giving two results holds it for both; the queue absorbs this and output stalls.
// Reset puts the parser at the line separator, clears the line-text flag and the
// queue, and sets plus mode. The configuration channel is always ready.
`default_nettype none

module at_response_line_parser_core import atrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] kind: byte or start of a new response
	input  wire logic        s_axis_tlast,   // last_in_chunk, does not affect parsing
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_char
	output logic             m_axis_tuser,   // [0] out_kind: character or line end
	output logic             m_axis_tlast,   // last_result of the input transaction
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data        // plus_mode
);

	atrp_qstat_t qstat;
	atrp_entry_t push_entry;
	atrp_entry_t head;
	logic        push;
	logic        pop;

	atrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_byte    (s_axis_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	atrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	atrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && qstat.full))
		else $error("entry written into a full queue");

	// A line-end result carries a zero character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == OUT_LINE_END) |-> (m_axis_tdata == 8'h00))
		else $error("line-end result with a nonzero character");

	// The second result of a byte follows right after the first is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("second result of a transaction did not follow");

	// An entry is only removed from the queue when one is there.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue popped while empty");

endmodule

`default_nettype wire
